/* rtl/cia402_pkg.sv */
// Shared types, codes and helpers for the CiA402 drive state machine.
`default_nettype none
package cia402_pkg;

    localparam logic [15:0] STATUS_VOLTAGE_ENABLED = 16'h0010;

    // Action bit positions in the invoked mask
    localparam int ACT_INIT      = 0;
    localparam int ACT_EN_POWER  = 1;
    localparam int ACT_DIS_POWER = 2;
    localparam int ACT_EN_DRIVE  = 3;
    localparam int ACT_DIS_DRIVE = 4;
    localparam int ACT_QSTOP     = 5;
    localparam int ACT_FAULT     = 6;
    localparam int ACT_COUNT     = 7;

    typedef enum logic [2:0] {
        ST_NOT_READY      = 3'd0,
        ST_SW_DISABLED    = 3'd1,
        ST_READY          = 3'd2,
        ST_SWITCHED_ON    = 3'd3,
        ST_OP_ENABLED     = 3'd4,
        ST_QUICK_STOP     = 3'd5,
        ST_FAULT_REACTION = 3'd6,
        ST_FAULT          = 3'd7
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE            = 4'd0,
        CMD_SHUTDOWN        = 4'd1,
        CMD_SWITCH_ON       = 4'd2,
        CMD_DISABLE_VOLTAGE = 4'd3,
        CMD_QUICK_STOP      = 4'd4,
        CMD_DISABLE_OP      = 4'd5,
        CMD_ENABLE_OP       = 4'd6,
        CMD_FAULT_RESET     = 4'd7
    } t_cmd;

    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    typedef struct packed {
        logic        state_action_ok;
        logic        fault_handled;
        logic [1:0]  quick_stop_status;
        logic [1:0]  disable_drive_status;
        logic [1:0]  enable_drive_status;
        logic [1:0]  disable_power_status;
        logic [1:0]  enable_power_status;
        logic [1:0]  init_status;
        logic [15:0] ctrl_word;
        logic        kind;
    } t_item;

    typedef struct packed {
        logic                 fault_raised;
        logic                 clear_fault_flags;
        logic [ACT_COUNT-1:0] actions_invoked;
        logic                 cmd_rejected;
        logic [15:0]          drive_status;
        t_state               state_code;
    } t_result;

    function automatic logic [15:0] drive_status_of(input t_state st);
        logic [15:0] w;
        case (st)
            ST_NOT_READY:      w = 16'h0000;
            ST_SW_DISABLED:    w = 16'h0040;
            ST_READY:          w = 16'h0021;
            ST_SWITCHED_ON:    w = 16'h0023 | STATUS_VOLTAGE_ENABLED;
            ST_OP_ENABLED:     w = 16'h0027 | STATUS_VOLTAGE_ENABLED;
            ST_QUICK_STOP:     w = 16'h0007 | STATUS_VOLTAGE_ENABLED;
            ST_FAULT_REACTION: w = 16'h000F | STATUS_VOLTAGE_ENABLED;
            ST_FAULT:          w = 16'h0008;
            default:           w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/cia402_step.sv */
// Single-beat decode and transition logic of the CiA402 drive state machine.
`default_nettype none
module cia402_step (
    input  wire cia402_pkg::t_item   i_item,
    input  wire cia402_pkg::t_state  i_state,
    input  wire cia402_pkg::t_cmd    i_cmd,
    input  wire                      i_last_fr,
    output cia402_pkg::t_state       o_state,
    output cia402_pkg::t_cmd         o_cmd,
    output logic                     o_last_fr,
    output cia402_pkg::t_result      o_result
);
    import cia402_pkg::*;

    t_state               nxt;
    t_state               fin_state;
    t_cmd                 dec;
    logic                 invalid;
    logic                 clr;
    logic                 faulted;
    logic [ACT_COUNT-1:0] inv;
    logic [ACT_COUNT-1:0] err;
    logic                 fin_init, fin_enp, fin_disp, fin_end, fin_disd, fin_qs;

    assign fin_init = (i_item.init_status == 2'd1);
    assign fin_enp  = (i_item.enable_power_status == 2'd1);
    assign fin_disp = (i_item.disable_power_status == 2'd1);
    assign fin_end  = (i_item.enable_drive_status == 2'd1);
    assign fin_disd = (i_item.disable_drive_status == 2'd1);
    assign fin_qs   = (i_item.quick_stop_status == 2'd1);

    assign err = {1'b0,
                  i_item.quick_stop_status[1],
                  i_item.disable_drive_status[1],
                  i_item.enable_drive_status[1],
                  i_item.disable_power_status[1],
                  i_item.enable_power_status[1],
                  i_item.init_status[1]};

    // control word decode
    always_comb begin
        if (!i_last_fr && i_item.ctrl_word[7]) begin
            dec = CMD_FAULT_RESET;
        end else if (!i_item.ctrl_word[1]) begin
            dec = CMD_DISABLE_VOLTAGE;
        end else if (!i_item.ctrl_word[2]) begin
            dec = CMD_QUICK_STOP;
        end else if (!i_item.ctrl_word[0]) begin
            dec = CMD_SHUTDOWN;
        end else if (i_item.ctrl_word[3]) begin
            dec = CMD_ENABLE_OP;
        end else begin
            dec = CMD_SWITCH_ON;
        end
        if (i_state == ST_OP_ENABLED && dec == CMD_SWITCH_ON) begin
            dec = CMD_DISABLE_OP;
        end
    end

    // transition table
    always_comb begin
        nxt     = i_state;
        invalid = 1'b0;
        clr     = 1'b0;
        inv     = '0;
        case (i_state)
            ST_NOT_READY: begin
                inv[ACT_INIT] = 1'b1;
                if (fin_init) nxt = ST_SW_DISABLED;
            end
            ST_SW_DISABLED: begin
                if (i_cmd == CMD_SHUTDOWN) nxt = ST_READY;
                else if (i_cmd != CMD_DISABLE_VOLTAGE) invalid = 1'b1;
            end
            ST_READY: begin
                if (i_cmd == CMD_SWITCH_ON) begin
                    inv[ACT_EN_POWER] = 1'b1;
                    if (fin_enp) nxt = ST_SWITCHED_ON;
                end else if (i_cmd == CMD_QUICK_STOP || i_cmd == CMD_DISABLE_VOLTAGE) begin
                    inv[ACT_DIS_POWER] = 1'b1;
                    if (fin_disp) nxt = ST_SW_DISABLED;
                end else if (i_cmd == CMD_ENABLE_OP) begin
                    inv[ACT_EN_POWER] = 1'b1;
                    if (fin_enp) begin
                        nxt = ST_SWITCHED_ON;
                        inv[ACT_EN_DRIVE] = 1'b1;
                        if (fin_end) nxt = ST_OP_ENABLED;
                    end
                end else begin
                    invalid = 1'b1;
                end
            end
            ST_SWITCHED_ON: begin
                if (i_cmd == CMD_ENABLE_OP) begin
                    inv[ACT_EN_POWER] = 1'b1;
                    if (fin_enp) begin
                        inv[ACT_EN_DRIVE] = 1'b1;
                        if (fin_end) nxt = ST_OP_ENABLED;
                    end
                end else if (i_cmd == CMD_DISABLE_VOLTAGE || i_cmd == CMD_QUICK_STOP
                             || i_cmd == CMD_SHUTDOWN) begin
                    inv[ACT_DIS_DRIVE] = 1'b1;
                    if (fin_disd) begin
                        inv[ACT_DIS_POWER] = 1'b1;
                        if (fin_disp) begin
                            nxt = (i_cmd == CMD_SHUTDOWN) ? ST_READY : ST_SW_DISABLED;
                        end
                    end
                end else begin
                    invalid = 1'b1;
                end
            end
            ST_OP_ENABLED: begin
                if (i_cmd == CMD_DISABLE_OP) begin
                    inv[ACT_DIS_DRIVE] = 1'b1;
                    if (fin_disd) nxt = ST_SWITCHED_ON;
                end else if (i_cmd == CMD_SHUTDOWN || i_cmd == CMD_DISABLE_VOLTAGE) begin
                    inv[ACT_DIS_DRIVE] = 1'b1;
                    if (fin_disd) begin
                        nxt = ST_SWITCHED_ON;
                        inv[ACT_DIS_POWER] = 1'b1;
                        if (fin_disp) begin
                            nxt = (i_cmd == CMD_SHUTDOWN) ? ST_READY : ST_SW_DISABLED;
                        end
                    end
                end else if (i_cmd == CMD_QUICK_STOP) begin
                    inv[ACT_QSTOP] = 1'b1;
                    if (fin_qs) nxt = ST_QUICK_STOP;
                end else if (i_cmd != CMD_ENABLE_OP) begin
                    invalid = 1'b1;
                end
            end
            ST_QUICK_STOP: begin
                if (i_cmd == CMD_DISABLE_VOLTAGE) begin
                    inv[ACT_DIS_DRIVE] = 1'b1;
                    if (fin_disd) begin
                        inv[ACT_DIS_POWER] = 1'b1;
                        if (fin_disp) nxt = ST_SW_DISABLED;
                    end
                end else if (i_cmd == CMD_ENABLE_OP) begin
                    inv[ACT_EN_DRIVE] = 1'b1;
                    if (fin_end) nxt = ST_OP_ENABLED;
                end else begin
                    invalid = 1'b1;
                end
            end
            ST_FAULT_REACTION: begin
                inv[ACT_FAULT] = 1'b1;
                if (i_item.fault_handled) nxt = ST_FAULT;
            end
            ST_FAULT: begin
                if (i_cmd == CMD_FAULT_RESET) begin
                    inv[ACT_INIT] = 1'b1;
                    if (fin_init) begin
                        clr = 1'b1;
                        nxt = ST_SW_DISABLED;
                    end
                end else begin
                    invalid = 1'b1;
                end
            end
            default: begin
                nxt = i_state;
            end
        endcase
    end

    assign faulted   = (|(inv & err)) || !i_item.state_action_ok;
    assign fin_state = faulted ? ST_FAULT_REACTION : nxt;

    always_comb begin
        if (i_item.kind == KIND_CONTROL) begin
            o_state                    = i_state;
            o_cmd                      = dec;
            o_last_fr                  = i_item.ctrl_word[7];
            o_result.state_code        = i_state;
            o_result.drive_status      = drive_status_of(i_state);
            o_result.cmd_rejected      = 1'b0;
            o_result.actions_invoked   = '0;
            o_result.clear_fault_flags = 1'b0;
            o_result.fault_raised      = 1'b0;
        end else begin
            o_state                    = fin_state;
            o_cmd                      = CMD_NONE;
            o_last_fr                  = i_last_fr;
            o_result.state_code        = fin_state;
            o_result.drive_status      = drive_status_of(fin_state);
            o_result.cmd_rejected      = invalid && (i_cmd != CMD_NONE);
            o_result.actions_invoked   = inv;
            o_result.clear_fault_flags = clr;
            o_result.fault_raised      = faulted;
        end
    end

endmodule
`default_nettype wire

/* rtl/cia402_drive_state_machine.sv */
// Top level of the CiA402 drive state machine with stream input and output.
//
// Input stream: one beat per item. tuser carries kind (0 control word,
// 1 update tick); tdata carries the control word and the drive action results.
// A control word beat latches a pending command decoded from bits 0-3 and 7;
// an update beat applies the drive state transition and clears that command.
// Every input beat yields exactly one output beat with the state code, the
// status word and the per-update flags.
// An input beat is held in the input register, then the transition logic feeds the
// result register. Throughput is one beat per cycle while the receiver keeps
// tready high; the state update of one beat is visible to the next beat.
// Reset (synchronous, active low) returns to not ready to switch on with no
// pending command and empties both registers.
// When the receiver stalls, the result register holds its beat and the input
// register keeps at most one more beat; tready drops once both are full.
`default_nettype none
module cia402_drive_state_machine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] ctrl_word, [17:16] init_status, [19:18] enable_power_status,
    // [21:20] disable_power_status, [23:22] enable_drive_status,
    // [25:24] disable_drive_status, [27:26] quick_stop_status,
    // [28] fault_handled, [29] state_action_ok, [31:30] zero
    input  wire  [31:0] i_s_axis_tdata,
    // [0] kind
    input  wire         i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [2:0] state_code, [18:3] drive_status, [19] cmd_rejected,
    // [26:20] actions_invoked, [27] clear_fault_flags, [28] fault_raised,
    // [31:29] zero
    output logic [31:0] o_m_axis_tdata
);
    import cia402_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cmd    r_cmd;
    logic    r_last_fr;

    t_state  n_state;
    t_cmd    n_cmd;
    logic    n_last_fr;
    t_result n_out;
    logic    advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

    cia402_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cmd    (r_cmd),
        .i_last_fr(r_last_fr),
        .o_state  (n_state),
        .o_cmd    (n_cmd),
        .o_last_fr(n_last_fr),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_NOT_READY;
            r_cmd       <= CMD_NONE;
            r_last_fr   <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_cmd       <= n_cmd;
                r_last_fr   <= n_last_fr;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= {i_s_axis_tdata[29:0], i_s_axis_tuser};
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_fault_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.fault_raised |-> r_out.state_code == ST_FAULT_REACTION)
        else $error("fault raised without fault reaction state");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clear_fault_flags && !r_out.fault_raised |->
            r_out.state_code == ST_SW_DISABLED)
        else $error("fault clear strobe outside switch on disabled");

    a_update_clears_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_UPDATE |=> r_cmd == CMD_NONE)
        else $error("pending command survived an update");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state) && $stable(r_cmd))
        else $error("state changed without a processed beat");

    a_control_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_CONTROL |=>
            r_out.actions_invoked == '0 && !r_out.cmd_rejected && !r_out.fault_raised)
        else $error("control word beat produced update flags");

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking stream testbench for the CiA402 drive state machine.
`timescale 1ns / 1ps
module tb;
    import cia402_pkg::*;

    localparam int ITEMS        = 1050;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    // drive action status coding
    localparam logic [1:0] AS_ONGOING = 2'd0;
    localparam logic [1:0] AS_DONE    = 2'd1;
    localparam logic [1:0] AS_ERROR   = 2'd2;
    localparam logic [1:0] AS_BAD     = 2'd3;

    localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON       = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP       = 16'h000F;
    localparam logic [15:0] CW_QUICK_STOP      = 16'h0002;
    localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
    localparam logic [15:0] CW_FAULT_RESET     = 16'h0080;

    typedef struct {
        t_item   it;
        logic    typed;
        t_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;    // ctrl_word, six action statuses, fault_handled, ok
    logic        i_s_axis_tuser;    // [0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;    // state, status word, rejected, actions, clear, fault

    cia402_drive_state_machine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predictor state
    t_state               drv_state;
    t_cmd                 pend_cmd;
    logic                 prev_fr_bit;
    logic [ACT_COUNT-1:0] consulted;
    logic                 act_fault;

    t_result   drive_reports[$];
    t_stim_row stim_rows[$];

    int   mismatches = 0;
    int   n_items    = 0;
    int   n_ctl      = 0;
    int   n_upd      = 0;
    int   n_faults   = 0;
    int   n_invalid  = 0;
    int   cycle_cnt  = 0;
    logic [7:0] states_seen = '0;
    logic quiet    = 1'b0;
    logic hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [15:0] word_for(input t_state s);
        logic [15:0] w;
        case (s)
            ST_NOT_READY:      w = 16'h0000;
            ST_SW_DISABLED:    w = 16'h0040;
            ST_READY:          w = 16'h0021;
            ST_SWITCHED_ON:    w = 16'h0023;
            ST_OP_ENABLED:     w = 16'h0027;
            ST_QUICK_STOP:     w = 16'h0007;
            ST_FAULT_REACTION: w = 16'h000F;
            default:           w = 16'h0008;
        endcase
        if (s inside {ST_SWITCHED_ON, ST_OP_ENABLED, ST_QUICK_STOP, ST_FAULT_REACTION})
            w = w | STATUS_VOLTAGE_ENABLED;
        return w;
    endfunction

    function automatic logic [ACT_COUNT-1:0] amask(input int a);
        logic [ACT_COUNT-1:0] m;
        m = '0;
        m[a] = 1'b1;
        return m;
    endfunction

    // marks an action as consulted; true once it has finished, codes 2 and 3 are errors
    function automatic logic consult(input int which, input logic [1:0] st);
        consulted[which] = 1'b1;
        if (st >= AS_ERROR) begin
            act_fault = 1'b1;
            return 1'b0;
        end
        return st == AS_DONE;
    endfunction

    function automatic t_result advance_drive(input t_item it);
        t_result r;
        t_state  cur;
        t_state  nxt;
        t_cmd    cmd;
        t_cmd    dec;
        logic    bad;
        logic    clr;
        r = '0;
        cur = drv_state;
        cmd = pend_cmd;
        nxt = cur;
        bad = 1'b0;
        clr = 1'b0;
        consulted = '0;
        act_fault = 1'b0;
        if (it.kind == KIND_CONTROL) begin
            if (!prev_fr_bit && it.ctrl_word[7])
                dec = CMD_FAULT_RESET;
            else if (!it.ctrl_word[1])
                dec = CMD_DISABLE_VOLTAGE;
            else if (!it.ctrl_word[2])
                dec = CMD_QUICK_STOP;
            else if (!it.ctrl_word[0])
                dec = CMD_SHUTDOWN;
            else if (it.ctrl_word[3])
                dec = CMD_ENABLE_OP;
            else
                dec = CMD_SWITCH_ON;
            if (cur == ST_OP_ENABLED && dec == CMD_SWITCH_ON)
                dec = CMD_DISABLE_OP;
            pend_cmd = dec;
            prev_fr_bit = it.ctrl_word[7];
            r.state_code = cur;
            r.drive_status = word_for(cur);
            return r;
        end
        case (cur)
            ST_NOT_READY: begin
                if (consult(ACT_INIT, it.init_status))
                    nxt = ST_SW_DISABLED;
            end
            ST_SW_DISABLED: begin
                if (cmd == CMD_SHUTDOWN)
                    nxt = ST_READY;
                else if (cmd != CMD_DISABLE_VOLTAGE)
                    bad = 1'b1;
            end
            ST_READY: begin
                if (cmd == CMD_SWITCH_ON) begin
                    if (consult(ACT_EN_POWER, it.enable_power_status))
                        nxt = ST_SWITCHED_ON;
                end else if (cmd == CMD_QUICK_STOP || cmd == CMD_DISABLE_VOLTAGE) begin
                    if (consult(ACT_DIS_POWER, it.disable_power_status))
                        nxt = ST_SW_DISABLED;
                end else if (cmd == CMD_ENABLE_OP) begin
                    if (consult(ACT_EN_POWER, it.enable_power_status)) begin
                        nxt = ST_SWITCHED_ON;
                        if (consult(ACT_EN_DRIVE, it.enable_drive_status))
                            nxt = ST_OP_ENABLED;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            ST_SWITCHED_ON: begin
                if (cmd == CMD_ENABLE_OP) begin
                    if (consult(ACT_EN_POWER, it.enable_power_status))
                        if (consult(ACT_EN_DRIVE, it.enable_drive_status))
                            nxt = ST_OP_ENABLED;
                end else if (cmd == CMD_DISABLE_VOLTAGE || cmd == CMD_QUICK_STOP) begin
                    if (consult(ACT_DIS_DRIVE, it.disable_drive_status))
                        if (consult(ACT_DIS_POWER, it.disable_power_status))
                            nxt = ST_SW_DISABLED;
                end else if (cmd == CMD_SHUTDOWN) begin
                    if (consult(ACT_DIS_DRIVE, it.disable_drive_status))
                        if (consult(ACT_DIS_POWER, it.disable_power_status))
                            nxt = ST_READY;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_OP_ENABLED: begin
                if (cmd == CMD_DISABLE_OP) begin
                    if (consult(ACT_DIS_DRIVE, it.disable_drive_status))
                        nxt = ST_SWITCHED_ON;
                end else if (cmd == CMD_SHUTDOWN || cmd == CMD_DISABLE_VOLTAGE) begin
                    if (consult(ACT_DIS_DRIVE, it.disable_drive_status)) begin
                        nxt = ST_SWITCHED_ON;
                        if (consult(ACT_DIS_POWER, it.disable_power_status)) begin
                            if (cmd == CMD_SHUTDOWN)
                                nxt = ST_READY;
                            else
                                nxt = ST_SW_DISABLED;
                        end
                    end
                end else if (cmd == CMD_QUICK_STOP) begin
                    if (consult(ACT_QSTOP, it.quick_stop_status))
                        nxt = ST_QUICK_STOP;
                end else if (cmd != CMD_ENABLE_OP) begin
                    bad = 1'b1;
                end
            end
            ST_QUICK_STOP: begin
                if (cmd == CMD_DISABLE_VOLTAGE) begin
                    if (consult(ACT_DIS_DRIVE, it.disable_drive_status))
                        if (consult(ACT_DIS_POWER, it.disable_power_status))
                            nxt = ST_SW_DISABLED;
                end else if (cmd == CMD_ENABLE_OP) begin
                    if (consult(ACT_EN_DRIVE, it.enable_drive_status))
                        nxt = ST_OP_ENABLED;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_FAULT_REACTION: begin
                consulted[ACT_FAULT] = 1'b1;
                if (it.fault_handled)
                    nxt = ST_FAULT;
            end
            default: begin
                if (cmd == CMD_FAULT_RESET) begin
                    if (consult(ACT_INIT, it.init_status)) begin
                        clr = 1'b1;
                        nxt = ST_SW_DISABLED;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
        endcase
        pend_cmd = CMD_NONE;
        // a fault outranks whatever transition was taken
        drv_state = act_fault ? ST_FAULT_REACTION : nxt;
        if (!it.state_action_ok) begin
            act_fault = 1'b1;
            drv_state = ST_FAULT_REACTION;
        end
        r.state_code = drv_state;
        r.drive_status = word_for(drv_state);
        r.cmd_rejected = bad && cmd != CMD_NONE;
        r.actions_invoked = consulted;
        r.clear_fault_flags = clr;
        r.fault_raised = act_fault;
        return r;
    endfunction

    function automatic t_item ctl_item(input logic [15:0] cw);
        t_item it;
        it = '0;
        it.kind = KIND_CONTROL;
        it.ctrl_word = cw;
        return it;
    endfunction

    function automatic t_item upd_item(input logic [1:0] s_ini, s_enp, s_dsp, s_edr, s_ddr,
                                       s_qs, input logic fh, ok);
        t_item it;
        it = '0;
        it.kind = KIND_UPDATE;
        it.init_status = s_ini;
        it.enable_power_status = s_enp;
        it.disable_power_status = s_dsp;
        it.enable_drive_status = s_edr;
        it.disable_drive_status = s_ddr;
        it.quick_stop_status = s_qs;
        it.fault_handled = fh;
        it.state_action_ok = ok;
        return it;
    endfunction

    function automatic t_result report(input t_state s, input logic [15:0] sw, input logic inv,
                                       input logic [ACT_COUNT-1:0] acts, input logic clr, fr);
        t_result r;
        r.state_code = s;
        r.drive_status = sw;
        r.cmd_rejected = inv;
        r.actions_invoked = acts;
        r.clear_fault_flags = clr;
        r.fault_raised = fr;
        return r;
    endfunction

    function automatic logic [1:0] rand_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return AS_DONE;
        if (r < 92) return AS_ONGOING;
        if (r < 97) return AS_ERROR;
        return AS_BAD;
    endfunction

    function automatic t_item rand_update();
        t_item it;
        it = t_item'(31'($urandom));
        it.kind = KIND_UPDATE;
        it.init_status = rand_status();
        it.enable_power_status = rand_status();
        it.disable_power_status = rand_status();
        it.enable_drive_status = rand_status();
        it.disable_drive_status = rand_status();
        it.quick_stop_status = rand_status();
        it.state_action_ok = ($urandom_range(0, 99) >= 4);
        return it;
    endfunction

    // command bits forced to a well-formed pattern most of the time
    function automatic t_item rand_control();
        logic [15:0] cw;
        cw = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       cw[3:0] = CW_SHUTDOWN[3:0];
            1, 2:    cw[3:0] = CW_SWITCH_ON[3:0];
            3, 4:    cw[3:0] = CW_ENABLE_OP[3:0];
            5:       cw[2:1] = CW_QUICK_STOP[2:1];
            6:       cw[1]   = CW_DISABLE_VOLTAGE[1];
            default: ;
        endcase
        cw[7] = ($urandom_range(0, 3) == 0);
        return ctl_item(cw);
    endfunction

    task automatic add_row(input t_item it);
        t_stim_row r;
        r.it = it;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endtask

    task automatic add_checked_row(input t_item it, input t_result want);
        t_stim_row r;
        r.it = it;
        r.typed = 1'b1;
        r.want = want;
        stim_rows.push_back(r);
    endtask

    task automatic send_item(input t_item it, input logic typed, input t_result want);
        t_result predicted;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= 32'(it >> 1);
        i_s_axis_tuser <= it.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = advance_drive(it);
        drive_reports.push_back(typed ? want : predicted);
        n_items++;
        if (it.kind == KIND_CONTROL) n_ctl++;
        else n_upd++;
        if (predicted.fault_raised) n_faults++;
        if (predicted.cmd_rejected) n_invalid++;
        states_seen[predicted.state_code] = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    initial begin : sink
        int n;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : report_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (drive_reports.size() == 0) begin
                $error("unexpected result beat %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = drive_reports.pop_front();
                if (got.state_code !== want.state_code) begin
                    $error("state_code expected %0d got %0d", want.state_code, got.state_code);
                    mismatches++;
                end
                if (got.drive_status !== want.drive_status) begin
                    $error("drive_status expected %h got %h",
                           want.drive_status, got.drive_status);
                    mismatches++;
                end
                if (got.cmd_rejected !== want.cmd_rejected) begin
                    $error("cmd_rejected expected %b got %b",
                           want.cmd_rejected, got.cmd_rejected);
                    mismatches++;
                end
                if (got.actions_invoked !== want.actions_invoked) begin
                    $error("actions_invoked expected %b got %b",
                           want.actions_invoked, got.actions_invoked);
                    mismatches++;
                end
                if (got.clear_fault_flags !== want.clear_fault_flags) begin
                    $error("clear_fault_flags expected %b got %b",
                           want.clear_fault_flags, got.clear_fault_flags);
                    mismatches++;
                end
                if (got.fault_raised !== want.fault_raised) begin
                    $error("fault_raised expected %b got %b", want.fault_raised, got.fault_raised);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row r;
        t_item     all_done;
        logic      hold_done;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= KIND_CONTROL;
        drv_state = ST_NOT_READY;
        pend_cmd = CMD_NONE;
        prev_fr_bit = 1'b0;
        hold_done = 1'b0;
        all_done = upd_item(AS_DONE, AS_DONE, AS_DONE, AS_DONE, AS_DONE, AS_DONE, 1'b1, 1'b1);

        add_checked_row(upd_item(AS_ONGOING, AS_ONGOING, AS_ONGOING, AS_ONGOING, AS_ONGOING,
                                 AS_ONGOING, 1'b0, 1'b1),
                        report(ST_NOT_READY, 16'h0000, 1'b0, amask(ACT_INIT), 1'b0, 1'b0));
        add_checked_row(ctl_item(16'hFFFF),
                        report(ST_NOT_READY, 16'h0000, 1'b0, '0, 1'b0, 1'b0));
        add_checked_row(upd_item(AS_DONE, AS_ONGOING, AS_ONGOING, AS_ONGOING, AS_ONGOING,
                                 AS_ONGOING, 1'b0, 1'b1),
                        report(ST_SW_DISABLED, 16'h0040, 1'b0, amask(ACT_INIT), 1'b0, 1'b0));
        add_row(ctl_item(CW_SHUTDOWN));
        add_row(all_done);
        add_row(ctl_item(CW_ENABLE_OP));
        add_row(all_done);                      // stacked ready -> operation enabled
        add_row(ctl_item(CW_SWITCH_ON));        // becomes disable operation
        add_row(upd_item(AS_DONE, AS_DONE, AS_DONE, AS_DONE, AS_ONGOING, AS_DONE, 1'b0, 1'b1));
        add_row(ctl_item(CW_QUICK_STOP));
        add_row(all_done);
        add_row(ctl_item(CW_ENABLE_OP));
        add_row(all_done);
        add_row(ctl_item(CW_DISABLE_VOLTAGE));
        add_row(upd_item(AS_DONE, AS_DONE, AS_ONGOING, AS_DONE, AS_DONE, AS_DONE, 1'b0, 1'b1));
        add_row(all_done);                      // no command pending
        add_row(ctl_item(CW_SHUTDOWN));
        add_row(all_done);
        add_row(ctl_item(CW_SWITCH_ON));
        add_checked_row(upd_item(AS_DONE, AS_BAD, AS_DONE, AS_DONE, AS_DONE, AS_DONE, 1'b0, 1'b1),
                        report(ST_FAULT_REACTION, 16'h001F, 1'b0, amask(ACT_EN_POWER),
                               1'b0, 1'b1));
        add_checked_row(upd_item(AS_DONE, AS_DONE, AS_DONE, AS_DONE, AS_DONE, AS_DONE, 1'b0, 1'b0),
                        report(ST_FAULT_REACTION, 16'h001F, 1'b0, amask(ACT_FAULT), 1'b0, 1'b1));
        add_checked_row(all_done,
                        report(ST_FAULT, 16'h0008, 1'b0, amask(ACT_FAULT), 1'b0, 1'b0));
        add_row(ctl_item(CW_FAULT_RESET));
        add_checked_row(all_done,
                        report(ST_SW_DISABLED, 16'h0040, 1'b0, amask(ACT_INIT), 1'b1, 1'b0));
        add_row(ctl_item(CW_SWITCH_ON));
        add_checked_row(all_done,
                        report(ST_SW_DISABLED, 16'h0040, 1'b1, '0, 1'b0, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            send_item(r.it, r.typed, r.want);
        end

        while (n_items < ITEMS) begin
            if (n_items >= ITEMS - QUIET_TAIL) quiet = 1'b1;
            if (!hold_done && n_items >= HOLD_AT) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 3) != 0) send_item(rand_control(), 1'b0, '0);
                send_item(rand_update(), 1'b0, '0);
            end else begin
                send_item(t_item'(31'($urandom)), 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (drive_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d control words, %0d update ticks, %0d forced faults, %0d rejected cmds",
                 n_ctl, n_upd, n_faults, n_invalid);
        $display("tb: drive states reached (bit per state code) %b", states_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* cia402_drive_state_machine.f */
rtl/cia402_pkg.sv
rtl/cia402_step.sv
rtl/cia402_drive_state_machine.sv
dv/tb.sv
